// ===== rtl/fatcc_pkg.sv =====
package fatcc_pkg;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_PLAN  = 2'd1;
   localparam logic [1:0] OP_COUNT = 2'd2;

   localparam logic KIND_SEG   = 1'b0;
   localparam logic KIND_COUNT = 1'b1;

   localparam logic [1:0] CSR_FIRST_LBA     = 2'd0;
   localparam logic [1:0] CSR_CLUSTER_SHIFT = 2'd1;
   localparam logic [1:0] CSR_SECTOR_SHIFT  = 2'd2;
   localparam logic [1:0] CSR_FAT_ENTRIES   = 2'd3;

   localparam logic [31:0] END_MARK = 32'h0fff_fff8;
   localparam logic [31:0] BAD_MARK = 32'h0fff_fff7;

   localparam logic [3:0] SECTOR_SHIFT_MIN = 4'd9;
   localparam logic [3:0] SECTOR_SHIFT_MAX = 4'd12;

   // one read segment as it travels from the address stage to the output
   typedef struct packed {
      logic [47:0] lba;
      logic [18:0] coff;
      logic [19:0] cnt;
      logic [31:0] dest;
   } seg_type;

endpackage

// ===== rtl/fat32_cluster_chain_read_planner.sv =====
// Table write (opcode 0) and unused opcode are accepted back to back.
// Chain walk (opcodes 1, 2): each table read is a read step, then an evaluate step on the word;
// the walk ends with the end check, the final result and the return to idle, or stops
// from the evaluate step when a bad mark or a cap is met.
// Stalls: a segment or the final result waits while the output register is full.
// Reset clears control state and loads the register defaults; the table is not cleared.
module fat32_cluster_chain_read_planner
   import fatcc_pkg::*;
#(
   parameter int FAT_DEPTH    = 65536,
   parameter int MAX_SEGMENTS = 64
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_wdata,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_entry_index,
   input  logic [31:0] req_entry_value,
   input  logic [31:0] req_start_cluster,
   input  logic [31:0] req_range_offset,
   input  logic [31:0] req_range_size,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [47:0] rsp_sector_address,
   output logic [18:0] rsp_cluster_offset,
   output logic [19:0] rsp_byte_count,
   output logic [31:0] rsp_dest_offset,
   output logic [16:0] rsp_chain_length,
   output logic        rsp_truncated,
   output logic        rsp_last
);

   localparam int AW  = $clog2(FAT_DEPTH);
   localparam int SW  = $clog2(FAT_DEPTH + 1);
   localparam int NW  = $clog2(MAX_SEGMENTS + 1);
   localparam int CNT_LIMIT = (FAT_DEPTH < 65536) ? FAT_DEPTH : 65536;
   localparam logic [32:0]   DEPTH_W  = 33'(FAT_DEPTH);
   localparam logic [SW-1:0] STEP_CAP = SW'(FAT_DEPTH);
   localparam logic [SW-1:0] CNT_CAP  = SW'(CNT_LIMIT);
   localparam logic [NW-1:0] SEG_CAP  = NW'(MAX_SEGMENTS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_EVAL = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   // configuration
   logic [47:0] first_lba_ff;
   logic [2:0]  cl_shift_ff;
   logic [3:0]  sec_shift_ff;
   logic [16:0] fat_entries_ff;

   // table
   logic [31:0]   fat_mem [FAT_DEPTH];
   logic [31:0]   rdata_ff;
   logic          rd_en;
   logic          wr_en;

   // walk control
   logic [1:0]    state_ff, state_in;
   logic [1:0]    op_ff;
   logic [31:0]   cl_ff;
   logic [33:0]   fidx_ff;
   logic [33:0]   ftop_ff;
   logic [32:0]   end_ff;
   logic [31:0]   off_ff;
   logic [SW-1:0] steps_ff;
   logic [31:0]   dest_ff;
   logic [NW-1:0] nseg_ff;
   logic          trunc_ff;
   seg_type       seg_ff, seg_in;
   logic          seg_ovl_ff, seg_ovl_in;
   seg_type       pend_ff;
   logic          pend_valid_ff;

   // output register
   logic          rsp_valid_ff;
   logic          rsp_kind_ff;
   seg_type       rsp_seg_ff;
   logic [16:0]   rsp_len_ff;
   logic          rsp_trunc_ff;
   logic          rsp_last_ff;

   logic          req_fire;
   logic          out_free;
   logic [3:0]    sec_sat;
   logic [4:0]    csize_exp;
   logic [19:0]   csize;
   logic          cl_in_range;
   logic          walk_go;
   logic [33:0]   off_w;
   logic [33:0]   end_w;
   logic [33:0]   seg_b;
   logic [33:0]   seg_e;
   logic          eval_bad;
   logic          eval_trunc;
   logic          eval_stall;
   logic          rsp_load;

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      req_fire  = req_valid && req_ready;
      out_free  = !rsp_valid_ff || rsp_ready;

      sec_sat = sec_shift_ff;
      if (sec_shift_ff < SECTOR_SHIFT_MIN) begin
         sec_sat = SECTOR_SHIFT_MIN;
      end else if (sec_shift_ff > SECTOR_SHIFT_MAX) begin
         sec_sat = SECTOR_SHIFT_MAX;
      end
      csize_exp = 5'(cl_shift_ff) + 5'(sec_sat);
      csize     = 20'd1 << csize_exp;

      cl_in_range = (cl_ff >= 32'd2) && (cl_ff < END_MARK) &&
                    (cl_ff < 32'(fat_entries_ff)) && ({1'b0, cl_ff} < DEPTH_W);
      walk_go = cl_in_range && ((op_ff != OP_PLAN) || (fidx_ff < {1'b0, end_ff}));
      rd_en   = (state_ff == ST_WALK) && walk_go;
      wr_en   = req_fire && (req_opcode == OP_WRITE) && (33'(req_entry_index) < DEPTH_W);

      // segment geometry for the cluster about to be read
      off_w      = 34'(off_ff);
      end_w      = 34'(end_ff);
      seg_ovl_in = ftop_ff > off_w;
      seg_b      = (fidx_ff > off_w) ? fidx_ff : off_w;
      seg_e      = (ftop_ff < end_w) ? ftop_ff : end_w;
      seg_in.coff = 19'(seg_b - fidx_ff);
      seg_in.cnt  = 20'(seg_e - seg_b);
      seg_in.lba  = first_lba_ff + (48'(cl_ff - 32'd2) << cl_shift_ff);
      seg_in.dest = dest_ff;

      eval_bad   = (rdata_ff == BAD_MARK);
      eval_trunc = (op_ff == OP_PLAN) ?
                   ((steps_ff >= STEP_CAP) || (seg_ovl_ff && (nseg_ff >= SEG_CAP))) :
                   (steps_ff >= CNT_CAP);
      eval_stall = (op_ff == OP_PLAN) && seg_ovl_ff && pend_valid_ff && !out_free;

      // output register takes a pushed segment or the final result
      rsp_load = ((state_ff == ST_EVAL) && !eval_bad && !eval_trunc && !eval_stall &&
                  (op_ff == OP_PLAN) && seg_ovl_ff && pend_valid_ff) ||
                 ((state_ff == ST_FIN) && out_free);

      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && ((req_opcode == OP_PLAN) || (req_opcode == OP_COUNT))) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            state_in = walk_go ? ST_EVAL : ST_FIN;
         end
         ST_EVAL: begin
            if (eval_bad || eval_trunc) begin
               state_in = ST_FIN;
            end else if (!eval_stall) begin
               state_in = ST_WALK;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fat_mem[AW'(req_entry_index)] <= req_entry_value;
      end
      if (rd_en) begin
         rdata_ff <= fat_mem[cl_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_lba_ff   <= '0;
         cl_shift_ff    <= '0;
         sec_shift_ff   <= SECTOR_SHIFT_MIN;
         fat_entries_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIRST_LBA:     first_lba_ff   <= csr_wdata;
            CSR_CLUSTER_SHIFT: cl_shift_ff    <= csr_wdata[2:0];
            CSR_SECTOR_SHIFT:  sec_shift_ff   <= csr_wdata[3:0];
            CSR_FAT_ENTRIES:   fat_entries_ff <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  op_ff         <= req_opcode;
                  cl_ff         <= req_start_cluster;
                  off_ff        <= req_range_offset;
                  end_ff        <= {1'b0, req_range_offset} + {1'b0, req_range_size};
                  fidx_ff       <= '0;
                  ftop_ff       <= 34'(csize);
                  steps_ff      <= '0;
                  dest_ff       <= '0;
                  nseg_ff       <= '0;
                  pend_valid_ff <= 1'b0;
               end
            end
            ST_WALK: begin
               seg_ff     <= seg_in;
               seg_ovl_ff <= seg_ovl_in;
               trunc_ff   <= 1'b0;
            end
            ST_EVAL: begin
               if (eval_bad) begin
                  trunc_ff <= 1'b0;
               end else if (eval_trunc) begin
                  trunc_ff <= 1'b1;
               end else if (!eval_stall) begin
                  cl_ff    <= rdata_ff;
                  steps_ff <= steps_ff + SW'(1);
                  fidx_ff  <= ftop_ff;
                  ftop_ff  <= ftop_ff + 34'(csize);
                  if ((op_ff == OP_PLAN) && seg_ovl_ff) begin
                     // previous segment is no longer the last one: push it out
                     if (pend_valid_ff) begin
                        rsp_kind_ff  <= KIND_SEG;
                        rsp_seg_ff   <= pend_ff;
                        rsp_len_ff   <= '0;
                        rsp_trunc_ff <= 1'b0;
                        rsp_last_ff  <= 1'b0;
                     end
                     pend_ff       <= seg_ff;
                     pend_valid_ff <= 1'b1;
                     dest_ff       <= dest_ff + 32'(seg_ff.cnt);
                     nseg_ff       <= nseg_ff + NW'(1);
                  end
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  rsp_trunc_ff  <= trunc_ff;
                  rsp_last_ff   <= 1'b1;
                  pend_valid_ff <= 1'b0;
                  if (op_ff == OP_PLAN) begin
                     rsp_kind_ff <= KIND_SEG;
                     rsp_len_ff  <= '0;
                     rsp_seg_ff  <= pend_valid_ff ? pend_ff : '0;
                  end else begin
                     rsp_kind_ff <= KIND_COUNT;
                     rsp_len_ff  <= 17'(steps_ff);
                     rsp_seg_ff  <= '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_sector_address = rsp_seg_ff.lba;
   assign rsp_cluster_offset = rsp_seg_ff.coff;
   assign rsp_byte_count     = rsp_seg_ff.cnt;
   assign rsp_dest_offset    = rsp_seg_ff.dest;
   assign rsp_chain_length   = rsp_len_ff;
   assign rsp_truncated      = rsp_trunc_ff;
   assign rsp_last           = rsp_last_ff;

   a_count_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == KIND_COUNT) |-> rsp_last_ff)
      else $error("chain count transaction without last");

   a_trunc_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_trunc_ff || rsp_last_ff))
      else $error("truncated set on a transaction that is not last");

   a_pend_in_walk: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff != ST_IDLE) && (op_ff == OP_PLAN))
      else $error("pending segment outside a range walk");

   a_seg_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (nseg_ff <= SEG_CAP))
      else $error("segment count beyond cap");

endmodule

// ===== bench/fat32_cluster_chain_read_planner_test.sv =====
`timescale 1ns / 1ps

module fat32_cluster_chain_read_planner_test;
   import fatcc_pkg::*;

   localparam int FAT_DEPTH    = 65536;
   localparam int MAX_SEGMENTS = 64;
   localparam int COUNT_CAP    = 65536;
   localparam int LINK_POOL    = 64;       // random chains live mostly in clusters 0..63
   localparam int SETTLE       = 8;
   localparam int DEEP_WALK    = 1 << 20;
   localparam int SHORT_WALK   = 400;
   localparam int BLOCK_ITEMS  = 68;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] index;
      logic [31:0] value;
      logic [31:0] start;
      logic [31:0] offset;
      logic [31:0] size;
   } chain_req_type;

   typedef struct packed {
      logic        kind;
      logic [47:0] lba;
      logic [18:0] coff;
      logic [19:0] cnt;
      logic [31:0] dest;
      logic [16:0] clen;
      logic        trunc;
      logic        last;
   } planner_result_type;

   typedef struct packed {
      logic               is_csr;
      logic [1:0]         csr_index;
      logic [47:0]        csr_value;
      chain_req_type      req;
      logic               typed;
      planner_result_type want;
   } directed_row_type;

   typedef enum {WALK_OK, WALK_HOLE, WALK_LONG} walk_status_type;
   typedef enum {LINK_END, LINK_LIVE, LINK_HOLE} link_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [47:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = '0;
   logic [15:0] req_entry_index = '0;
   logic [31:0] req_entry_value = '0;
   logic [31:0] req_start_cluster = '0;
   logic [31:0] req_range_offset = '0;
   logic [31:0] req_range_size = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [47:0] rsp_sector_address;
   logic [18:0] rsp_cluster_offset;
   logic [19:0] rsp_byte_count;
   logic [31:0] rsp_dest_offset;
   logic [16:0] rsp_chain_length;
   logic        rsp_truncated;
   logic        rsp_last;

   // shadow of the block: table, which entries hold data, and registers
   logic [31:0] fat_shadow [0:FAT_DEPTH-1];
   bit          written [0:FAT_DEPTH-1];
   logic [47:0] cfg_lba = '0;
   logic [2:0]  cfg_css = '0;
   logic [3:0]  cfg_sbs = SECTOR_SHIFT_MIN;
   logic [16:0] cfg_entries = '0;

   planner_result_type pending_answers[$];
   planner_result_type head;
   directed_row_type   directed_rows[$];
   int mismatches = 0;
   int idle_pct = 9;
   int stall_pct = 69;

   fat32_cluster_chain_read_planner #(
      .FAT_DEPTH(FAT_DEPTH),
      .MAX_SEGMENTS(MAX_SEGMENTS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_entry_index(req_entry_index),
      .req_entry_value(req_entry_value),
      .req_start_cluster(req_start_cluster),
      .req_range_offset(req_range_offset),
      .req_range_size(req_range_size),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_sector_address(rsp_sector_address),
      .rsp_cluster_offset(rsp_cluster_offset),
      .rsp_byte_count(rsp_byte_count),
      .rsp_dest_offset(rsp_dest_offset),
      .rsp_chain_length(rsp_chain_length),
      .rsp_truncated(rsp_truncated),
      .rsp_last(rsp_last)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic [63:0] cluster_bytes();
      int sbs;
      sbs = int'(cfg_sbs);
      if (sbs < int'(SECTOR_SHIFT_MIN)) sbs = int'(SECTOR_SHIFT_MIN);
      if (sbs > int'(SECTOR_SHIFT_MAX)) sbs = int'(SECTOR_SHIFT_MAX);
      return 64'd1 << (int'(cfg_css) + sbs);
   endfunction

   // a hole is a cluster the walk would read although nothing was ever stored there
   function automatic link_type probe(input logic [31:0] c);
      if (c < 32'd2 || c >= END_MARK || c >= {15'd0, cfg_entries} || c >= FAT_DEPTH)
         return LINK_END;
      if (!written[c[15:0]])
         return LINK_HOLE;
      return (fat_shadow[c[15:0]] == BAD_MARK) ? LINK_END : LINK_LIVE;
   endfunction

   // Predicts the results of one transaction and applies table writes.
   // Walks that would touch a hole or run past step_limit are refused.
   function automatic walk_status_type plan_chain(input chain_req_type r, input int step_limit,
         output planner_result_type answers[$], output logic [31:0] stop_at);
      planner_result_type one;
      logic [63:0] csize, fidx, dest, span_end, first, stop, steps;
      logic [31:0] cl;
      link_type link;
      bit overlaps, trunc;
      answers.delete();
      stop_at = '0;
      trunc = 1'b0;
      cl = r.start;
      steps = '0;
      fidx = '0;
      dest = '0;
      case (r.opcode)
         OP_WRITE: begin
            fat_shadow[r.index] = r.value;
            written[r.index] = 1'b1;
         end
         OP_PLAN: begin
            csize = cluster_bytes();
            span_end = 64'(r.offset) + 64'(r.size);
            while (fidx < span_end) begin
               link = probe(cl);
               if (link == LINK_HOLE) begin
                  stop_at = cl;
                  return WALK_HOLE;
               end
               if (link == LINK_END) break;
               overlaps = (fidx + csize > 64'(r.offset));
               if (steps >= FAT_DEPTH || (overlaps && answers.size() >= MAX_SEGMENTS)) begin
                  trunc = 1'b1;
                  break;
               end
               if (steps >= step_limit) begin
                  stop_at = cl;
                  return WALK_LONG;
               end
               if (overlaps) begin
                  first = (fidx > 64'(r.offset)) ? fidx : 64'(r.offset);
                  stop = (fidx + csize < span_end) ? fidx + csize : span_end;
                  one = '0;
                  one.kind = KIND_SEG;
                  one.lba = cfg_lba + ({16'd0, cl - 32'd2} << cfg_css);
                  one.coff = 19'(first - fidx);
                  one.cnt = 20'(stop - first);
                  one.dest = dest[31:0];
                  answers.push_back(one);
                  dest += stop - first;
               end
               fidx += csize;
               cl = fat_shadow[cl[15:0]];
               steps++;
            end
            if (answers.size() == 0) begin
               one = '0;
               answers.push_back(one);
            end
         end
         OP_COUNT: begin
            forever begin
               link = probe(cl);
               if (link == LINK_HOLE) begin
                  stop_at = cl;
                  return WALK_HOLE;
               end
               if (link == LINK_END) break;
               if (steps >= COUNT_CAP) begin
                  trunc = 1'b1;
                  break;
               end
               if (steps >= step_limit) begin
                  stop_at = cl;
                  return WALK_LONG;
               end
               steps++;
               cl = fat_shadow[cl[15:0]];
            end
            one = '0;
            one.kind = KIND_COUNT;
            one.clen = 17'(steps);
            answers.push_back(one);
         end
         default: ;
      endcase
      if (answers.size() != 0) begin
         answers[answers.size() - 1].trunc = trunc;
         answers[answers.size() - 1].last = 1'b1;
      end
      return WALK_OK;
   endfunction

   function automatic logic [31:0] random_link();
      int pick;
      pick = $urandom_range(99);
      if (pick < 50) return $urandom_range(0, LINK_POOL - 1);
      if (pick < 70) return END_MARK + $urandom_range(0, 7);
      if (pick < 80) return BAD_MARK;
      return $urandom;
   endfunction

   function automatic directed_row_type req_row(input logic [1:0] op, input logic [15:0] idx,
         input logic [31:0] val, input logic [31:0] start, input logic [31:0] off,
         input logic [31:0] size);
      req_row = '0;
      req_row.req = '{op, idx, val, start, off, size};
   endfunction

   function automatic directed_row_type csr_row(input logic [1:0] idx, input logic [47:0] val);
      csr_row = '0;
      csr_row.is_csr = 1'b1;
      csr_row.csr_index = idx;
      csr_row.csr_value = val;
   endfunction

   function automatic directed_row_type with_answer(input directed_row_type row,
         input planner_result_type want);
      row.typed = 1'b1;
      row.want = want;
      return row;
   endfunction

   function automatic planner_result_type count_answer(input logic [16:0] len,
         input logic trunc);
      count_answer = '0;
      count_answer.kind = KIND_COUNT;
      count_answer.clen = len;
      count_answer.trunc = trunc;
      count_answer.last = 1'b1;
   endfunction

   function automatic planner_result_type empty_plan(input logic trunc);
      empty_plan = '0;
      empty_plan.trunc = trunc;
      empty_plan.last = 1'b1;
   endfunction

   task automatic check_field(input string name, input logic [63:0] got,
         input logic [63:0] want);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            $display("%0t ns: result transaction with nothing pending", $time);
         end else begin
            head = pending_answers.pop_front();
            check_field("kind", rsp_kind, head.kind);
            check_field("sector_address", rsp_sector_address, head.lba);
            check_field("cluster_offset", rsp_cluster_offset, head.coff);
            check_field("byte_count", rsp_byte_count, head.cnt);
            check_field("dest_offset", rsp_dest_offset, head.dest);
            check_field("chain_length", rsp_chain_length, head.clen);
            check_field("truncated", rsp_truncated, head.trunc);
            check_field("last", rsp_last, head.last);
         end
      end
   end

   // leaves valid high after acceptance unless the sender idles
   task automatic issue_request(input chain_req_type r, input planner_result_type answers[$]);
      req_valid <= 1'b1;
      req_opcode <= r.opcode;
      req_entry_index <= r.index;
      req_entry_value <= r.value;
      req_start_cluster <= r.start;
      req_range_offset <= r.offset;
      req_range_size <= r.size;
      do @(posedge clock); while (!req_ready);
      foreach (answers[i]) pending_answers.push_back(answers[i]);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [47:0] data);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FIRST_LBA:     cfg_lba = data;
         CSR_CLUSTER_SHIFT: cfg_css = data[2:0];
         CSR_SECTOR_SHIFT:  cfg_sbs = data[3:0];
         CSR_FAT_ENTRIES:   cfg_entries = data[16:0];
         default: ;
      endcase
   endtask

   initial begin
      #50_000_000;
      $display("fat32_cluster_chain_read_planner_test NOT OK");
      $finish;
   end

   initial begin
      chain_req_type      r;
      planner_result_type predicted[$];
      walk_status_type    status;
      logic [31:0]        stop_at;
      logic [63:0]        csize;
      int                 pick;

      // chain 2-3-4 ends at the end mark, 5 is bad, 6 and 7 loop, 8 leads below 2
      directed_rows = '{
         with_answer(req_row(OP_COUNT, 0, 0, 2, 0, 0), count_answer(0, 0)),
         with_answer(req_row(OP_PLAN, 0, 0, 5, 0, 1), empty_plan(0)),
         req_row(OP_UNUSED, 16'hffff, '1, '1, '1, '1),
         req_row(OP_WRITE, 16'hffff, 32'hffff_ffff, 0, 0, 0),
         req_row(OP_WRITE, 2, 3, 0, 0, 0),
         req_row(OP_WRITE, 3, 4, 0, 0, 0),
         req_row(OP_WRITE, 4, END_MARK, 0, 0, 0),
         req_row(OP_WRITE, 5, BAD_MARK, 0, 0, 0),
         req_row(OP_WRITE, 6, 7, 0, 0, 0),
         req_row(OP_WRITE, 7, 6, 0, 0, 0),
         req_row(OP_WRITE, 8, 1, 0, 0, 0),
         csr_row(CSR_FAT_ENTRIES, 48'd65536),
         csr_row(CSR_FIRST_LBA, 48'hffff_ffff_ffff),
         csr_row(CSR_CLUSTER_SHIFT, 48'd7),
         csr_row(CSR_SECTOR_SHIFT, 48'd15),
         req_row(OP_PLAN, 0, 0, 2, 0, 32'hffff_ffff),
         req_row(OP_PLAN, 0, 0, 2, 32'h0008_0001, 1),
         req_row(OP_COUNT, 0, 0, 2, 0, 0),
         with_answer(req_row(OP_COUNT, 0, 0, 5, 0, 0), count_answer(0, 0)),
         with_answer(req_row(OP_COUNT, 0, 0, 32'hffff_ffff, 0, 0), count_answer(0, 0)),
         with_answer(req_row(OP_PLAN, 0, 0, 8, 0, 0), empty_plan(0)),
         with_answer(req_row(OP_COUNT, 0, 0, 6, 0, 0), count_answer(17'h1_0000, 1)),
         csr_row(CSR_CLUSTER_SHIFT, 48'd0),
         csr_row(CSR_SECTOR_SHIFT, 48'd0),
         csr_row(CSR_FIRST_LBA, 48'h1234_5678_9abc),
         req_row(OP_PLAN, 0, 0, 6, 0, 32'hffff_ffff),
         with_answer(req_row(OP_PLAN, 0, 0, 6, 32'hffff_ffff, 32'hffff_ffff), empty_plan(1)),
         with_answer(req_row(OP_COUNT, 0, 0, 1, 0, 0), count_answer(0, 0)),
         req_row(OP_PLAN, 0, 0, 8, 100, 1000)
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            write_csr(directed_rows[i].csr_index, directed_rows[i].csr_value);
         end else begin
            status = plan_chain(directed_rows[i].req, DEEP_WALK, predicted, stop_at);
            if (directed_rows[i].typed) begin
               predicted.delete();
               predicted.push_back(directed_rows[i].want);
            end
            issue_request(directed_rows[i].req, predicted);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 9 : (phase == 1) ? 69 : 0;
         stall_pct = (phase == 0) ? 69 : (phase == 1) ? 9 : 0;
         for (int blk = 0; blk < 2; blk++) begin
            pick = $urandom_range(9);
            write_csr(CSR_FIRST_LBA, (pick < 3) ? 48'd0 : (pick < 6) ? '1 :
                      48'({$urandom, $urandom}));
            write_csr(CSR_CLUSTER_SHIFT, 48'($urandom_range(0, 7)));
            write_csr(CSR_SECTOR_SHIFT, 48'($urandom_range(0, 15)));
            pick = $urandom_range(9);
            write_csr(CSR_FAT_ENTRIES, (pick < 1) ? 48'd0 : (pick < 2) ? 48'd2 :
                      (pick < 6) ? 48'(LINK_POOL) : (pick < 8) ? 48'd65536 :
                      48'($urandom_range(3, 65536)));
            csize = cluster_bytes();
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
               r = '{2'($urandom), 16'($urandom), $urandom, $urandom, $urandom, $urandom};
               pick = $urandom_range(99);
               r.opcode = (pick < 30) ? OP_WRITE : (pick < 75) ? OP_PLAN :
                          (pick < 95) ? OP_COUNT : OP_UNUSED;
               if (r.opcode == OP_WRITE) begin
                  if ($urandom_range(99) < 70) r.index = 16'($urandom_range(0, LINK_POOL - 1));
                  r.value = random_link();
               end else begin
                  if ($urandom_range(99) < 80) r.start = $urandom_range(0, LINK_POOL - 1);
                  pick = $urandom_range(99);
                  if (pick < 60) r.offset = $urandom_range(0, 32'(csize * 4));
                  else if (pick < 80) r.offset = '0;
                  pick = $urandom_range(99);
                  if (pick < 60) r.size = $urandom_range(0, 32'(csize * 6));
                  else if (pick < 80) r.size = $urandom_range(0, 3);
               end
               status = plan_chain(r, SHORT_WALK, predicted, stop_at);
               // refused walks become a write that fills the hole or cuts the loop
               if (status != WALK_OK) begin
                  r.opcode = OP_WRITE;
                  r.index = stop_at[15:0];
                  r.value = (status == WALK_HOLE) ? random_link() :
                            END_MARK + $urandom_range(0, 7);
                  status = plan_chain(r, SHORT_WALK, predicted, stop_at);
               end
               issue_request(r, predicted);
            end
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("fat32_cluster_chain_read_planner_test OK");
      else
         $display("fat32_cluster_chain_read_planner_test NOT OK");
      $finish;
   end

endmodule
